// ----- sv/avi_movi_frame_extractor_top_macros.svh -----
// Assertion helpers for the checker file of the frame extractor.
`ifndef AVI_MOVI_FRAME_EXTRACTOR_TOP_MACROS_SVH
`define AVI_MOVI_FRAME_EXTRACTOR_TOP_MACROS_SVH

// Assert a property on a given clock, disabled while the given reset is low.
`define AFX_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assert a property on the block clock and reset.
`define AFX_ASSERT(lbl, prop, msg) \
  `AFX_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- sv/afx_pkg.sv -----
package afx_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgHeaderBytes   = 2'd0;
  localparam logic [1:0] CfgTargetFrame   = 2'd1;
  localparam logic [1:0] CfgMaxFrameBytes = 2'd2;

  // Configuration reset values
  localparam logic [15:0] HeaderBytesRst   = 16'd0;
  localparam logic [15:0] TargetFrameRst   = 16'd12;
  localparam logic [31:0] MaxFrameBytesRst = 32'd65536;

  // Chunk tags as they appear in byte order, first byte in the top bits
  localparam logic [31:0] TagVideo = 32'h3030_6463;  // "00dc"
  localparam logic [31:0] TagIndex = 32'h6964_7831;  // "idx1"

  // Result queue geometry
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // One result word
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        done_res;
    logic        found;
    logic [31:0] frame_length;
  } res_t;

  // Front-to-queue transfer
  typedef struct packed {
    logic valid;
    res_t res;
  } res_push_t;

endpackage

// ----- sv/afx_front.sv -----
module afx_front import afx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        item_acc_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        stream_end_i,
  output res_push_t   push_o
);

  typedef enum logic [2:0] {
    PhHeader  = 3'd0,
    PhTag     = 3'd1,
    PhSize    = 3'd2,
    PhSkip    = 3'd3,
    PhPayload = 3'd4,
    PhDone    = 3'd5
  } phase_e;

  logic [15:0] header_bytes_q, target_frame_q;
  logic [31:0] max_frame_bytes_q;

  phase_e      phase_q, phase_d;
  logic [31:0] skip_q, skip_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic [1:0]  fbi_q, fbi_d;
  logic [15:0] frames_q, frames_d;
  logic [31:0] len_q, len_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_bytes_q    <= HeaderBytesRst;
      target_frame_q    <= TargetFrameRst;
      max_frame_bytes_q <= MaxFrameBytesRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgHeaderBytes:   header_bytes_q    <= cfg_data_i[15:0];
        CfgTargetFrame:   target_frame_q    <= cfg_data_i[15:0];
        CfgMaxFrameBytes: max_frame_bytes_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Classify the incoming word and advance the chunk walk
  always_comb begin
    phase_e      ph;
    logic [31:0] skip_c, tag_c, size_c, len_c, skip_inc, new_size;
    logic [1:0]  fbi_c;
    logic [15:0] frames_c;
    logic        take_tag;

    // a first byte restarts from the stream start state
    ph       = first_byte_i ? PhHeader : phase_q;
    skip_c   = first_byte_i ? '0 : skip_q;
    tag_c    = first_byte_i ? '0 : tag_q;
    size_c   = first_byte_i ? '0 : size_q;
    fbi_c    = first_byte_i ? '0 : fbi_q;
    frames_c = first_byte_i ? '0 : frames_q;
    len_c    = first_byte_i ? '0 : len_q;

    skip_inc = skip_c + 32'd1;
    new_size = {data_byte_i, size_c[31:8]};
    take_tag = 1'b0;

    phase_d  = ph;
    skip_d   = skip_c;
    tag_d    = tag_c;
    size_d   = size_c;
    fbi_d    = fbi_c;
    frames_d = frames_c;
    len_d    = len_c;
    push_o   = '0;

    if (ph == PhDone) begin
      phase_d = PhDone;
    end else if (stream_end_i) begin
      phase_d             = PhDone;
      push_o.valid        = 1'b1;
      push_o.res.done_res = 1'b1;
    end else begin
      unique case (ph)
        PhHeader: begin
          if (skip_c < {16'd0, header_bytes_q}) begin
            skip_d = skip_inc;
          end else begin
            take_tag = 1'b1;
            fbi_c    = '0;
          end
        end
        PhTag: take_tag = 1'b1;
        PhSize: begin
          size_d = new_size;
          if (fbi_c == 2'd3) begin
            fbi_d  = '0;
            len_d  = new_size;
            skip_d = '0;
            if (tag_c == TagIndex) begin
              phase_d             = PhDone;
              push_o.valid        = 1'b1;
              push_o.res.done_res = 1'b1;
            end else if (tag_c == TagVideo && frames_c == target_frame_q &&
                         new_size != '0 && new_size <= max_frame_bytes_q) begin
              phase_d = PhPayload;
            end else begin
              if (tag_c == TagVideo) frames_d = frames_c + 16'd1;
              phase_d = (new_size == '0) ? PhTag : PhSkip;
            end
          end else begin
            fbi_d = fbi_c + 2'd1;
          end
        end
        PhSkip: begin
          if (skip_inc >= len_c) begin
            skip_d  = '0;
            phase_d = PhTag;
          end else begin
            skip_d = skip_inc;
          end
        end
        PhPayload: begin
          skip_d                   = skip_inc;
          push_o.valid             = 1'b1;
          push_o.res.payload_byte  = data_byte_i;
          push_o.res.payload_valid = 1'b1;
          if (skip_inc >= len_c) begin
            phase_d                 = PhDone;
            push_o.res.done_res     = 1'b1;
            push_o.res.found        = 1'b1;
            push_o.res.frame_length = len_c;
          end
        end
        default: phase_d = PhDone;
      endcase

      // shift a tag byte in, big end first
      if (take_tag) begin
        tag_d = {tag_c[23:0], data_byte_i};
        if (fbi_c == 2'd3) begin
          fbi_d   = '0;
          phase_d = PhSize;
        end else begin
          fbi_d   = fbi_c + 2'd1;
          phase_d = PhTag;
        end
      end
    end

    if (!item_acc_i) begin
      push_o.valid = 1'b0;
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHeader;
      skip_q   <= '0;
      tag_q    <= '0;
      size_q   <= '0;
      fbi_q    <= '0;
      frames_q <= '0;
      len_q    <= '0;
    end else if (item_acc_i) begin
      phase_q  <= phase_d;
      skip_q   <= skip_d;
      tag_q    <= tag_d;
      size_q   <= size_d;
      fbi_q    <= fbi_d;
      frames_q <= frames_d;
      len_q    <= len_d;
    end
  end

endmodule

// ----- sv/afx_queue.sv -----
module afx_queue import afx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_push_t push_i,
  output logic      full_o,
  output logic      empty_o,
  input  logic      pop_i,
  output res_t      head_o
);

  res_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // Store result words
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.res;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      if (do_pop)  rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      if (do_push && !do_pop)      cnt_q <= cnt_q + QCntW'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - QCntW'(1);
    end
  end

endmodule

// ----- sv/avi_movi_frame_extractor_top.sv -----
// AVI frame extractor: push one file byte per word (first_byte_i marks file offset zero,
// stream_end_i marks the end of the file and carries no byte). After header_bytes bytes
// the block walks the chunks, counts 00dc chunks and streams out the bytes of the
// target frame, the last one flagged done with found set and the frame length; an idx1
// tag, a truncated frame or the end of the stream gives a single done word with found
// clear, and later bytes give nothing until the next first byte. The parser state is
// registered and a byte is taken every cycle while full is low; results pass through a
// four-word queue, and full is raised only while that queue holds four unread words.
module avi_movi_frame_extractor_top import afx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        stream_end_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic        done_res_o,
  output logic        found_o,
  output logic [31:0] frame_length_o
);

  res_push_t front_push;
  res_t      head;
  logic      item_acc;

  assign item_acc = push && !full;

  afx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_acc_i   (item_acc),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .stream_end_i (stream_end_i),
    .push_o       (front_push)
  );

  afx_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .full_o  (full),
    .empty_o (empty),
    .pop_i   (pop),
    .head_o  (head)
  );

  assign payload_byte_o  = head.payload_byte;
  assign payload_valid_o = head.payload_valid;
  assign done_res_o      = head.done_res;
  assign found_o         = head.found;
  assign frame_length_o  = head.frame_length;

endmodule

// ----- sv/afx_checker.sv -----
`include "avi_movi_frame_extractor_top_macros.svh"

module afx_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  payload_byte_o,
  input logic        payload_valid_o,
  input logic        done_res_o,
  input logic        found_o,
  input logic [31:0] frame_length_o
);

  // Hold a waiting word until it is popped
  `AFX_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(frame_length_o) && $stable(payload_byte_o)), "result word changed while stalled")

  // A found word is the last frame byte
  `AFX_ASSERT(a_found_last, (!empty && found_o) |-> (done_res_o && payload_valid_o), "found without done or byte")

  // A word without a byte is a done word with nothing else set
  `AFX_ASSERT(a_no_byte, (!empty && !payload_valid_o) |-> (done_res_o && !found_o && payload_byte_o == 8'd0), "empty byte word malformed")

  // Length shows only on a found word
  `AFX_ASSERT(a_len_zero, (!empty && !found_o) |-> (frame_length_o == 32'd0), "length without found")

  // Full and empty never hold together
  `AFX_ASSERT(a_full_empty, !(full && empty), "queue full and empty")

endmodule

bind avi_movi_frame_extractor_top afx_checker u_afx_checker (.*);

// ----- verif/afx_frame_check.sv -----
module afx_frame_check import afx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        stream_end_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        payload_valid_i,
  input  logic        done_res_i,
  input  logic        found_i,
  input  logic [31:0] frame_length_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef enum logic [2:0] {
    PhHeader,
    PhTag,
    PhSize,
    PhSkip,
    PhPayload,
    PhDone
  } parse_phase_e;

  // Register copies
  logic [15:0]  hdr_len;
  logic [15:0]  target_idx;
  logic [31:0]  max_len;

  // Parser copy
  parse_phase_e phase;
  logic [31:0]  skipped;
  logic [31:0]  tag_acc;
  logic [31:0]  size_acc;
  logic [31:0]  chunk_len;
  logic [1:0]   byte_idx;
  logic [15:0]  frames;
  logic         finished;

  res_t         frame_words_q[$];
  res_t         got_word;
  res_t         want_word;

  function automatic void start_new_search();
    phase    = PhHeader;
    skipped  = '0;
    tag_acc  = '0;
    size_acc = '0;
    chunk_len = '0;
    byte_idx = '0;
    frames   = '0;
    finished = 1'b0;
  endfunction

  // Advance the parser by one file word and queue the word it should emit
  function automatic void predict_frame_word(logic [7:0] b, logic first, logic ends);
    res_t word;
    word = '0;
    if (first) start_new_search();
    if (phase == PhDone || finished) begin
      phase    = PhDone;
      finished = 1'b1;
      return;
    end
    if (ends) begin
      phase    = PhDone;
      finished = 1'b1;
      word.done_res = 1'b1;
      frame_words_q.push_back(word);
      return;
    end
    if (phase == PhHeader) begin
      if (skipped < {16'd0, hdr_len}) begin
        skipped++;
        return;
      end
      phase    = PhTag;
      byte_idx = '0;
    end
    case (phase)
      PhTag: begin
        tag_acc = {tag_acc[23:0], b};
        if (byte_idx == 2'd3) begin
          byte_idx = '0;
          phase    = PhSize;
        end else begin
          byte_idx++;
        end
      end
      PhSize: begin
        size_acc = {b, size_acc[31:8]};
        if (byte_idx == 2'd3) begin
          byte_idx  = '0;
          chunk_len = size_acc;
          skipped   = '0;
          if (tag_acc == TagIndex) begin
            phase = PhDone;
          end else if (tag_acc == TagVideo && frames == target_idx &&
                       size_acc != 0 && size_acc <= max_len) begin
            phase = PhPayload;
          end else begin
            // every video chunk that is not taken still counts as a frame
            if (tag_acc == TagVideo) frames++;
            phase = (size_acc == 0) ? PhTag : PhSkip;
          end
          if (phase == PhDone) begin
            finished = 1'b1;
            word.done_res = 1'b1;
            frame_words_q.push_back(word);
          end
        end else begin
          byte_idx++;
        end
      end
      PhSkip: begin
        skipped++;
        if (skipped >= chunk_len) begin
          skipped = '0;
          phase   = PhTag;
        end
      end
      PhPayload: begin
        skipped++;
        word.payload_byte  = b;
        word.payload_valid = 1'b1;
        if (skipped >= chunk_len) begin
          phase    = PhDone;
          finished = 1'b1;
          word.done_res     = 1'b1;
          word.found        = 1'b1;
          word.frame_length = chunk_len;
        end
        frame_words_q.push_back(word);
      end
      default: begin
        phase    = PhDone;
        finished = 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count_o++;
    end
  endfunction

  assign got_word = '{payload_byte:  payload_byte_i,
                      payload_valid: payload_valid_i,
                      done_res:      done_res_i,
                      found:         found_i,
                      frame_length:  frame_length_i};

  // Track registers, predict on accepted input words, compare on popped words
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hdr_len    = HeaderBytesRst;
      target_idx = TargetFrameRst;
      max_len    = MaxFrameBytesRst;
      start_new_search();
      frame_words_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgHeaderBytes:   hdr_len    = cfg_data_i[15:0];
          CfgTargetFrame:   target_idx = cfg_data_i[15:0];
          CfgMaxFrameBytes: max_len    = cfg_data_i;
          default: ;
        endcase
      end
      if (push_i && !full_i) begin
        predict_frame_word(data_byte_i, first_byte_i, stream_end_i);
      end
      if (pop_i && !empty_i) begin
        if (frame_words_q.size() == 0) begin
          $error("unexpected result word: payload_byte %0h valid %0b done %0b found %0b",
                 payload_byte_i, payload_valid_i, done_res_i, found_i);
          fail_count_o++;
        end else begin
          want_word = frame_words_q.pop_front();
          check_field("payload_byte", want_word.payload_byte, got_word.payload_byte);
          check_field("payload_valid", want_word.payload_valid, got_word.payload_valid);
          check_field("done_res", want_word.done_res, got_word.done_res);
          check_field("found", want_word.found, got_word.found);
          check_field("frame_length", want_word.frame_length, got_word.frame_length);
        end
      end
    end
    pending_o = frame_words_q.size();
  end

endmodule

// ----- verif/avi_movi_frame_extractor_top_tb.sv -----
module avi_movi_frame_extractor_top_tb;
  import afx_pkg::*;

  localparam logic [1:0] CfgSpare = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        stream_end;
  logic        empty;
  logic        pop;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        done_res;
  logic        found;
  logic [31:0] frame_length;

  int          fail_count;
  int          pending;

  logic        tx_idle_on;
  logic        rx_idle_on;
  logic        hold_req;
  logic [15:0] cur_header;
  int          random_items;
  logic [7:0]  file_bytes[$];

  avi_movi_frame_extractor_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .push            (push),
    .full            (full),
    .data_byte_i     (data_byte),
    .first_byte_i    (first_byte),
    .stream_end_i    (stream_end),
    .empty           (empty),
    .pop             (pop),
    .payload_byte_o  (payload_byte),
    .payload_valid_o (payload_valid),
    .done_res_o      (done_res),
    .found_o         (found),
    .frame_length_o  (frame_length)
  );

  afx_frame_check frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .push_i          (push),
    .full_i          (full),
    .data_byte_i     (data_byte),
    .first_byte_i    (first_byte),
    .stream_end_i    (stream_end),
    .empty_i         (empty),
    .pop_i           (pop),
    .payload_byte_i  (payload_byte),
    .payload_valid_i (payload_valid),
    .done_res_i      (done_res),
    .found_i         (found),
    .frame_length_i  (frame_length),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bound the run
  initial begin
    #200_000;
    $display("avi_movi_frame_extractor_top: mismatch");
    $finish;
  end

  // Pop side: random idling, one long hold-off on request
  initial begin
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        pop <= 1'b0;
        repeat (150) @(negedge clk_i);
      end
      pop <= !rx_idle_on || ($urandom_range(99) >= 17);
    end
  end

  // Offer one word; return right after the edge that takes it
  task automatic send_word(input logic [7:0] b, input logic f, input logic e);
    @(negedge clk_i);
    while (tx_idle_on && $urandom_range(99) < 17) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push       <= 1'b1;
    data_byte  <= b;
    first_byte <= f;
    stream_end <= e;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Send the first n file bytes, then optionally an end-of-stream word
  task automatic send_file(input logic restart, input logic with_end, input int n);
    for (int i = 0; i < n; i++) begin
      send_word(file_bytes.pop_front(), restart && i == 0, 1'b0);
    end
    if (with_end) send_word(8'($urandom_range(255)), 1'b0, 1'b1);
    random_items += n + int'(with_end);
  endtask

  // Stop offering, wait for every expected word, then let the parser settle
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [15:0] h, input logic [15:0] t, input logic [31:0] m);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgHeaderBytes;
    cfg_data <= {16'd0, h};
    @(negedge clk_i);
    cfg_idx  <= CfgTargetFrame;
    cfg_data <= {16'd0, t};
    @(negedge clk_i);
    cfg_idx  <= CfgMaxFrameBytes;
    cfg_data <= m;
    @(negedge clk_i);
    // an index past the register list must be ignored
    cfg_idx  <= CfgSpare;
    cfg_data <= $urandom();
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    cur_header = h;
  endtask

  task automatic random_config();
    logic [15:0] h;
    logic [15:0] t;
    logic [31:0] m;
    h = ($urandom_range(99) < 40) ? 16'd0 : 16'($urandom_range(1, 8));
    t = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 3));
    case ($urandom_range(5))
      0:       m = 32'd0;
      1:       m = 32'd1;
      2:       m = $urandom_range(2, 30);
      3:       m = 32'hFFFF_FFFF;
      4:       m = MaxFrameBytesRst;
      default: m = $urandom();
    endcase
    apply_config(h, t, m);
  endtask

  function automatic void add_tag(logic [31:0] t);
    file_bytes.push_back(t[31:24]);
    file_bytes.push_back(t[23:16]);
    file_bytes.push_back(t[15:8]);
    file_bytes.push_back(t[7:0]);
  endfunction

  function automatic void add_len(logic [31:0] n);
    file_bytes.push_back(n[7:0]);
    file_bytes.push_back(n[15:8]);
    file_bytes.push_back(n[23:16]);
    file_bytes.push_back(n[31:24]);
  endfunction

  function automatic void add_fill(int unsigned n);
    repeat (n) file_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Mostly well-formed chunk walks with random tags, sizes and cut points
  function automatic void build_random_file();
    int unsigned hdr;
    int unsigned pick;
    int unsigned n_chunks;
    logic [31:0] t;
    logic [31:0] len;
    logic        stop;
    stop = 1'b0;
    hdr = ($urandom_range(9) == 0) ? $urandom_range(0, cur_header + 3) : cur_header;
    add_fill(hdr);
    n_chunks = $urandom_range(1, 6);
    for (int c = 0; c < n_chunks && !stop; c++) begin
      if ($urandom_range(19) == 0) begin
        // cut inside a chunk header
        add_fill($urandom_range(1, 7));
        stop = 1'b1;
      end else begin
        pick = $urandom_range(99);
        if (pick < 60)      t = TagVideo;
        else if (pick < 68) t = TagIndex;
        else if (pick < 80) t = TagVideo ^ (32'd1 << $urandom_range(31));
        else                t = $urandom();
        pick = $urandom_range(99);
        if (pick < 15)      len = 32'd0;
        else if (pick < 90) len = $urandom_range(1, 24);
        else                len = $urandom();
        add_tag(t);
        add_len(len);
        if (len > 24) begin
          add_fill($urandom_range(0, 30));
          stop = 1'b1;
        end else if ($urandom_range(19) == 0) begin
          add_fill($urandom_range(0, len));
          stop = 1'b1;
        end else begin
          add_fill(len);
        end
      end
    end
  endfunction

  initial begin
    int unsigned pick;
    int unsigned cut;
    int          stream_no;
    rst_ni     = 1'b0;
    cfg_we     = 1'b0;
    cfg_idx    = CfgHeaderBytes;
    cfg_data   = '0;
    push       = 1'b0;
    data_byte  = '0;
    first_byte = 1'b0;
    stream_end = 1'b0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    hold_req   = 1'b0;
    cur_header = HeaderBytesRst;
    random_items = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Index tag on a stream that never saw a first byte
    add_tag(TagIndex);
    add_len(32'h8000_00FF);
    send_file(1'b0, 1'b0, file_bytes.size());
    // Ignored after the answer, then a restart that ends at once
    send_word(8'h5A, 1'b0, 1'b0);
    send_word(8'($urandom_range(255)), 1'b1, 1'b1);
    drain();

    // Short header, frame zero of two bytes, just under the limit
    apply_config(16'd2, 16'd0, 32'd3);
    file_bytes.push_back(8'hFF);
    file_bytes.push_back(8'h00);
    add_tag(TagVideo);
    add_len(32'd2);
    file_bytes.push_back(8'h00);
    file_bytes.push_back(8'hFF);
    send_file(1'b1, 1'b0, file_bytes.size());
    drain();

    // Hold the pop side while a long frame streams in
    apply_config(16'd0, 16'd0, MaxFrameBytesRst);
    add_tag(TagVideo);
    add_len(32'd40);
    add_fill(40);
    hold_req = 1'b1;
    send_file(1'b1, 1'b1, file_bytes.size());
    drain();

    // Longer header, then a run of empty frames before the target one
    tx_idle_on = 1'b0;
    apply_config(16'd30, 16'd5, 32'hFFFF_FFFF);
    add_fill(30);
    repeat (5) begin
      add_tag(TagVideo);
      add_len(32'd0);
    end
    add_tag(TagVideo);
    add_len(32'd3);
    add_fill(3);
    send_file(1'b1, 1'b1, file_bytes.size());
    drain();
    tx_idle_on = 1'b1;
    random_config();

    // Random streams
    random_items = 0;
    stream_no    = 0;
    while (random_items < 400) begin
      tx_idle_on = !(stream_no >= 4 && stream_no < 10);
      rx_idle_on = tx_idle_on;
      if ($urandom_range(3) == 0) begin
        drain();
        random_config();
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
        send_word(8'($urandom_range(255)), 1'b1, 1'b1);
        random_items++;
      end else begin
        build_random_file();
        if (pick == 1 && file_bytes.size() > 1) begin
          // change registers partway through a stream
          cut = $urandom_range(1, file_bytes.size() - 1);
          send_file(1'b1, 1'b0, cut);
          drain();
          random_config();
          send_file(1'b0, 1'b1, file_bytes.size());
        end else begin
          send_file(pick != 2, pick != 3, file_bytes.size());
        end
      end
      // trailing noise without a first byte
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
        end
      end
      stream_no++;
    end

    drain();
    if (fail_count == 0) begin
      $display("avi_movi_frame_extractor_top: match");
    end else begin
      $display("avi_movi_frame_extractor_top: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+sv
sv/afx_pkg.sv
sv/afx_front.sv
sv/afx_queue.sv
sv/avi_movi_frame_extractor_top.sv
sv/afx_checker.sv
verif/afx_frame_check.sv
verif/avi_movi_frame_extractor_top_tb.sv
